/* sv/bmi_pkg.sv */
`default_nettype none
package bmi_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LIM_BITS   = 16;
  localparam int LANES      = 9;

  // Register stages from an accepted item to the cofactors and the determinant.
  localparam int COF_STAGES = 8;

  // Cofactors are differences of two word products; the determinant is a sum of three
  // word-by-cofactor products.
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int COF_BITS   = 2 * WORD_BITS + 1;
  localparam int DET_BITS   = 3 * WORD_BITS + 1;
  localparam int DMAG_BITS  = 3 * WORD_BITS;
  localparam int AN_BITS    = 2 * WORD_BITS;
  localparam int SHIFT_BITS = 2 * FRAC_BITS + 1;
  localparam int NUM_BITS   = ((AN_BITS + SHIFT_BITS > DMAG_BITS) ?
                               (AN_BITS + SHIFT_BITS) : DMAG_BITS) + 1;
  localparam int DEN_BITS   = DMAG_BITS + 1;
  localparam int REM_BITS   = DEN_BITS;
  localparam int HI_BITS    = NUM_BITS - WORD_BITS;
  localparam int CMP_BITS   = (HI_BITS > DEN_BITS) ? HI_BITS : DEN_BITS;

  localparam logic [LIM_BITS-1:0] LIM_RESET = LIM_BITS'(1);

  // Cyclic successors used by the cross products.
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    ORD_NONE  = 3'd0,
    ORD_AB    = 3'd1,
    ORD_AC    = 3'd2,
    ORD_BC    = 3'd3,
    ORD_AB_BC = 3'd4,
    ORD_AC_BC = 3'd5
  } order_e;

  typedef struct packed {
    word_t a_x;
    word_t a_y;
    word_t a_z;
    word_t b_x;
    word_t b_y;
    word_t b_z;
    word_t c_x;
    word_t c_y;
    word_t c_z;
  } bmi_in_t;

  typedef struct packed {
    word_t      inv_00;
    word_t      inv_01;
    word_t      inv_02;
    word_t      inv_10;
    word_t      inv_11;
    word_t      inv_12;
    word_t      inv_20;
    word_t      inv_21;
    word_t      inv_22;
    logic [2:0] order_code;
    logic       singular;
  } bmi_out_t;

  typedef struct packed {
    order_e code;
    logic   sing;
  } meta_t;

  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [WORD_BITS-1:0] low;
    logic [WORD_BITS-1:0] quo;
    logic [DEN_BITS-1:0]  den;
    logic                 neg;
    logic                 ovf;
  } div_lane_t;

  function automatic logic [WORD_BITS-1:0] mag_f(input word_t x);
    mag_f = x[WORD_BITS-1] ? (~x + 1'b1) : x;
  endfunction

endpackage
`default_nettype wire

/* sv/basis_matrix_inverse_3x3.sv */
`default_nettype none
// Throughput: one item per cycle; the cofactor and determinant pipeline, three divider
// setup stages and a chain of 32 divider cells (one quotient bit per cell) all advance
// together, and the whole pipeline holds while a result is stalled at the output.
// Reset clears every valid bit and sets the near-zero limit lim_q to 1.
module basis_matrix_inverse_3x3 import bmi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmi_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmi_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LIM_BITS-1:0] cfg_data_i
);

  logic [LIM_BITS-1:0] lim_q;
  logic                en;

  logic                       cf_valid;
  logic signed [COF_BITS-1:0] cof [3][3];
  logic signed [DET_BITS-1:0] det;
  meta_t                      cf_meta;

  logic signed [DET_BITS-1:0] det_neg;
  logic signed [COF_BITS-1:0] cof_neg [3][3];

  logic                 v1_q, v2_q, v3_q;
  logic [AN_BITS-1:0]   an1_q [LANES];
  logic [DMAG_BITS-1:0] ad1_q;
  logic                 neg1_q [LANES];
  logic                 neg2_q [LANES];
  meta_t                meta1_q, meta2_q, meta3_q;
  logic [NUM_BITS-1:0]  num2_q [LANES];
  logic [DEN_BITS-1:0]  den2_q;
  logic [HI_BITS-1:0]   hi2 [LANES];
  div_lane_t            head_d [LANES];
  div_lane_t            head_q [LANES];

  div_lane_t chain_lane [WORD_BITS+1][LANES];
  meta_t     chain_meta [WORD_BITS+1];
  logic      chain_v    [WORD_BITS+1];

  logic [WORD_BITS-1:0] lim_v [LANES];
  logic [WORD_BITS-1:0] mag_v [LANES];
  word_t                res_v [LANES];
  bmi_out_t             out_d, out_q;
  logic                 out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIM_RESET;
    end else if (cfg_valid_i) begin
      lim_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;

  bmi_cofactor u_cofactor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .in_i    (in_data_i),
    .lim_i   (lim_q),
    .valid_o (cf_valid),
    .cof_o   (cof),
    .det_o   (det),
    .meta_o  (cf_meta)
  );

  always_comb begin
    det_neg = -det;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        cof_neg[i][k] = -cof[i][k];
      end
    end
  end

  // Divider head: an item whose quotient needs more than a word saturates later.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      hi2[l]        = num2_q[l][NUM_BITS-1:WORD_BITS];
      head_d[l].ovf = CMP_BITS'(hi2[l]) >= CMP_BITS'(den2_q);
      head_d[l].rem = REM_BITS'(hi2[l]);
      head_d[l].low = num2_q[l][WORD_BITS-1:0];
      head_d[l].quo = '0;
      head_d[l].den = den2_q;
      head_d[l].neg = neg2_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= cf_valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ad1_q <= det[DET_BITS-1] ? det_neg[DMAG_BITS-1:0] : det[DMAG_BITS-1:0];
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          an1_q[3*i+k]  <= cof[i][k][COF_BITS-1] ? cof_neg[i][k][AN_BITS-1:0]
                                                  : cof[i][k][AN_BITS-1:0];
          neg1_q[3*i+k] <= cof[i][k][COF_BITS-1] ^ det[DET_BITS-1];
        end
      end
      meta1_q.code <= cf_meta.code;
      meta1_q.sing <= cf_meta.sing || (det == '0);

      // Rounded quotient is floor((2*|n| + |d|) / (2*|d|)) with n scaled by the fraction.
      for (int l = 0; l < LANES; l++) begin
        num2_q[l] <= (NUM_BITS'(an1_q[l]) << SHIFT_BITS) + NUM_BITS'(ad1_q);
      end
      den2_q  <= {ad1_q, 1'b0};
      neg2_q  <= neg1_q;
      meta2_q <= meta1_q;

      head_q  <= head_d;
      meta3_q <= meta2_q;
    end
  end

  assign chain_lane[0] = head_q;
  assign chain_meta[0] = meta3_q;
  assign chain_v[0]    = v3_q;

  for (genvar j = 0; j < WORD_BITS; j++) begin : g_cell
    bmi_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[j]),
      .lane_i  (chain_lane[j]),
      .meta_i  (chain_meta[j]),
      .valid_o (chain_v[j+1]),
      .lane_o  (chain_lane[j+1]),
      .meta_o  (chain_meta[j+1])
    );
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lim_v[l] = chain_lane[WORD_BITS][l].neg ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                              : {1'b0, {(WORD_BITS-1){1'b1}}};
      mag_v[l] = (chain_lane[WORD_BITS][l].ovf || chain_lane[WORD_BITS][l].quo > lim_v[l])
               ? lim_v[l] : chain_lane[WORD_BITS][l].quo;
      res_v[l] = chain_lane[WORD_BITS][l].neg ? (~mag_v[l] + 1'b1) : mag_v[l];
      if (chain_meta[WORD_BITS].sing) begin
        res_v[l] = '0;
      end
    end
    out_d.inv_00     = res_v[0];
    out_d.inv_01     = res_v[1];
    out_d.inv_02     = res_v[2];
    out_d.inv_10     = res_v[3];
    out_d.inv_11     = res_v[4];
    out_d.inv_12     = res_v[5];
    out_d.inv_20     = res_v[6];
    out_d.inv_21     = res_v[7];
    out_d.inv_22     = res_v[8];
    out_d.order_code = chain_meta[WORD_BITS].code;
    out_d.singular   = chain_meta[WORD_BITS].sing;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_v[WORD_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.singular) |->
      (out_data_o.inv_00 == '0 && out_data_o.inv_01 == '0 && out_data_o.inv_02 == '0 &&
       out_data_o.inv_10 == '0 && out_data_o.inv_11 == '0 && out_data_o.inv_12 == '0 &&
       out_data_o.inv_20 == '0 && out_data_o.inv_21 == '0 && out_data_o.inv_22 == '0))
    else $error("singular item carries a nonzero inverse entry");

  a_hold_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(chain_v[0]) && $stable(v1_q)))
    else $error("pipeline moved while the output was stalled");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("item accepted while a stalled result holds the pipeline");
`endif

endmodule
`default_nettype wire

/* sv/bmi_cofactor.sv */
`default_nettype none
module bmi_cofactor import bmi_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  bmi_in_t                    in_i,
  input  logic [LIM_BITS-1:0]        lim_i,
  output logic                       valid_o,
  output logic signed [COF_BITS-1:0] cof_o [3][3],
  output logic signed [DET_BITS-1:0] det_o,
  output meta_t                      meta_o
);

  logic [COF_STAGES-1:0] vld_q;

  word_t  vin [3][3];
  word_t  v1_d [3][3];
  word_t  v1_q [3][3];
  word_t  v2_q [3][3];
  word_t  v3_d [3][3];
  word_t  v3_q [3][3];
  word_t  a4_q [3];
  word_t  a5_q [3];
  order_e code1_d, code1_q, code2_q, code3_d, code3_q, code4_q, code5_q;
  logic   ax_small, bx_small, bc_swap;
  logic   axz2_q, axz3_q, axz4_q, axz5_q;

  logic signed [PROD_BITS-1:0]    p1_q, p2_q;
  logic [WORD_BITS+LIM_BITS-1:0]  plim_q;
  logic signed [COF_BITS-1:0]     res3;
  logic [COF_BITS-1:0]            resmag3;
  logic signed [PROD_BITS-1:0]    pa_q [3][3];
  logic signed [PROD_BITS-1:0]    pb_q [3][3];
  logic signed [COF_BITS-1:0]     cof5_q [3][3];
  logic signed [COF_BITS-1:0]     cof6_q [3][3];
  logic signed [COF_BITS-1:0]     cof7_q [3][3];
  logic signed [COF_BITS-1:0]     cof8_q [3][3];
  logic signed [COF_BITS-1:0]     plo_q [3];
  logic signed [COF_BITS-1:0]     phi_q [3];
  logic signed [DET_BITS-1:0]     term_q [3];
  logic signed [DET_BITS-1:0]     det_q;
  meta_t                          meta6_q, meta7_q, meta8_q;

  assign vin[0][0] = in_i.a_x;
  assign vin[0][1] = in_i.a_y;
  assign vin[0][2] = in_i.a_z;
  assign vin[1][0] = in_i.b_x;
  assign vin[1][1] = in_i.b_y;
  assign vin[1][2] = in_i.b_z;
  assign vin[2][0] = in_i.c_x;
  assign vin[2][1] = in_i.c_y;
  assign vin[2][2] = in_i.c_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[COF_STAGES-2:0], valid_i};
    end
  end

  // First pivot choice: a small a.x swaps a with b, or with c when b.x is small too.
  always_comb begin
    ax_small = {{LIM_BITS{1'b0}}, mag_f(vin[0][0])} < {{WORD_BITS{1'b0}}, lim_i};
    bx_small = {{LIM_BITS{1'b0}}, mag_f(vin[1][0])} < {{WORD_BITS{1'b0}}, lim_i};
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        v1_d[i][k] = vin[i][k];
      end
    end
    code1_d = ORD_NONE;
    if (ax_small) begin
      if (bx_small) begin
        for (int k = 0; k < 3; k++) begin
          v1_d[0][k] = vin[2][k];
          v1_d[2][k] = vin[0][k];
        end
        code1_d = ORD_AC;
      end else begin
        for (int k = 0; k < 3; k++) begin
          v1_d[0][k] = vin[1][k];
          v1_d[1][k] = vin[0][k];
        end
        code1_d = ORD_AB;
      end
    end
  end

  // Second pivot choice: b nearly parallel to a in the xy plane trades places with c.
  always_comb begin
    res3    = COF_BITS'(p1_q) - COF_BITS'(p2_q);
    resmag3 = res3[COF_BITS-1] ? COF_BITS'(-res3) : res3;
    bc_swap = resmag3 < {{(COF_BITS-WORD_BITS-LIM_BITS){1'b0}}, plim_q};
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        v3_d[i][k] = v2_q[i][k];
      end
    end
    code3_d = code2_q;
    if (bc_swap) begin
      for (int k = 0; k < 3; k++) begin
        v3_d[1][k] = v2_q[2][k];
        v3_d[2][k] = v2_q[1][k];
      end
      case (code2_q)
        ORD_NONE: code3_d = ORD_BC;
        ORD_AB:   code3_d = ORD_AB_BC;
        ORD_AC:   code3_d = ORD_AC_BC;
        default:  code3_d = code2_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q    <= v1_d;
      code1_q <= code1_d;

      p1_q    <= v1_q[1][1] * v1_q[0][0];
      p2_q    <= v1_q[1][0] * v1_q[0][1];
      plim_q  <= lim_i * mag_f(v1_q[0][0]);
      axz2_q  <= (v1_q[0][0] == '0);
      v2_q    <= v1_q;
      code2_q <= code1_q;

      v3_q    <= v3_d;
      code3_q <= code3_d;
      axz3_q  <= axz2_q;

      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pa_q[i][k] <= v3_q[NXT1[i]][NXT1[k]] * v3_q[NXT2[i]][NXT2[k]];
          pb_q[i][k] <= v3_q[NXT1[i]][NXT2[k]] * v3_q[NXT2[i]][NXT1[k]];
        end
      end
      a4_q    <= v3_q[0];
      code4_q <= code3_q;
      axz4_q  <= axz3_q;

      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          cof5_q[i][k] <= COF_BITS'(pa_q[i][k]) - COF_BITS'(pb_q[i][k]);
        end
      end
      a5_q    <= a4_q;
      code5_q <= code4_q;
      axz5_q  <= axz4_q;

      // The word-by-cofactor product is split at the word boundary of the cofactor.
      for (int k = 0; k < 3; k++) begin
        plo_q[k] <= a5_q[k] * $signed({1'b0, cof5_q[0][k][WORD_BITS-1:0]});
        phi_q[k] <= a5_q[k] * $signed(cof5_q[0][k][COF_BITS-1:WORD_BITS]);
      end
      cof6_q       <= cof5_q;
      meta6_q.code <= code5_q;
      meta6_q.sing <= axz5_q || (cof5_q[2][2] == '0);

      for (int k = 0; k < 3; k++) begin
        term_q[k] <= (DET_BITS'(phi_q[k]) << WORD_BITS) + DET_BITS'(plo_q[k]);
      end
      cof7_q  <= cof6_q;
      meta7_q <= meta6_q;

      det_q   <= term_q[0] + term_q[1] + term_q[2];
      cof8_q  <= cof7_q;
      meta8_q <= meta7_q;
    end
  end

  assign valid_o = vld_q[COF_STAGES-1];
  assign cof_o   = cof8_q;
  assign det_o   = det_q;
  assign meta_o  = meta8_q;

endmodule
`default_nettype wire

/* sv/bmi_div_cell.sv */
`default_nettype none
module bmi_div_cell import bmi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_lane_t lane_i [LANES],
  input  meta_t     meta_i,
  output logic      valid_o,
  output div_lane_t lane_o [LANES],
  output meta_t     meta_o
);

  logic      valid_q;
  div_lane_t lane_d [LANES];
  div_lane_t lane_q [LANES];
  meta_t     meta_q;

  logic [REM_BITS:0] trial [LANES];
  logic [REM_BITS:0] diff  [LANES];
  logic              ge    [LANES];

  // One restoring step per lane: bring down the next numerator bit, subtract if it fits.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l]      = {lane_i[l].rem, lane_i[l].low[WORD_BITS-1]};
      ge[l]         = trial[l] >= {1'b0, lane_i[l].den};
      diff[l]       = trial[l] - {1'b0, lane_i[l].den};
      lane_d[l]     = lane_i[l];
      lane_d[l].rem = ge[l] ? diff[l][REM_BITS-1:0] : trial[l][REM_BITS-1:0];
      lane_d[l].low = {lane_i[l].low[WORD_BITS-2:0], 1'b0};
      lane_d[l].quo = {lane_i[l].quo[WORD_BITS-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
  assign meta_o  = meta_q;

endmodule
`default_nettype wire

/* dv/tb_basis_matrix_inverse_3x3.sv */
`timescale 1ns / 100ps
module tb_basis_matrix_inverse_3x3;
  import bmi_pkg::*;

  typedef logic signed [255:0] wide_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  bmi_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  bmi_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [LIM_BITS-1:0] cfg_data_i;

  basis_matrix_inverse_3x3 uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  bmi_out_t            inverse_q[$];
  logic [LIM_BITS-1:0] limit_model;
  logic [LIM_BITS-1:0] limit_now;
  int                  errors;
  int                  results_seen;
  int                  singular_seen;
  int                  swaps_seen;
  int                  cycles;
  int                  burst_left;
  int                  stall_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Inverse entry: round(n / d), ties away from zero, clamped to the word range.
  function automatic word_t div_round_sat(wide_t n, wide_t d);
    logic [255:0] an, ad, q;
    logic         neg;
    neg = n[255] ^ d[255];
    an  = n[255] ? -n : n;
    ad  = d[255] ? -d : d;
    q   = (2 * an + ad) / (2 * ad);
    if (neg && q > 256'h8000_0000) q = 256'h8000_0000;
    if (!neg && q > 256'h7fff_ffff) q = 256'h7fff_ffff;
    return neg ? word_t'(-q[31:0]) : word_t'(q[31:0]);
  endfunction

  function automatic logic [32:0] mag33(word_t x);
    return x[31] ? 33'(-$signed({x[31], x})) : 33'(x);
  endfunction

  function automatic bmi_out_t predict_inverse(bmi_in_t x, logic [LIM_BITS-1:0] lim);
    word_t     v[3][3];
    word_t     t;
    wide_t     e[3][3];
    wide_t     cof[3][3];
    wide_t     det, res, thr;
    logic [2:0] code;
    logic      sing;
    bmi_out_t  r;
    word_t     w[9];
    v[0][0] = x.a_x; v[0][1] = x.a_y; v[0][2] = x.a_z;
    v[1][0] = x.b_x; v[1][1] = x.b_y; v[1][2] = x.b_z;
    v[2][0] = x.c_x; v[2][1] = x.c_y; v[2][2] = x.c_z;
    code = ORD_NONE;
    if (mag33(v[0][0]) < 33'(lim)) begin
      if (mag33(v[1][0]) < 33'(lim)) begin
        for (int k = 0; k < 3; k++) begin
          t = v[0][k]; v[0][k] = v[2][k]; v[2][k] = t;
        end
        code = ORD_AC;
      end else begin
        for (int k = 0; k < 3; k++) begin
          t = v[0][k]; v[0][k] = v[1][k]; v[1][k] = t;
        end
        code = ORD_AB;
      end
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) e[i][k] = wide_t'(v[i][k]);
    res = e[1][1] * e[0][0] - e[1][0] * e[0][1];
    if (res < 0) res = -res;
    thr = wide_t'(lim) * wide_t'(mag33(v[0][0]));
    if (res < thr) begin
      for (int k = 0; k < 3; k++) begin
        t = v[1][k]; v[1][k] = v[2][k]; v[2][k] = t;
        e[1][k] = wide_t'(v[1][k]); e[2][k] = wide_t'(v[2][k]);
      end
      code = code + 3'd3;
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        cof[i][k] = e[(i+1)%3][(k+1)%3] * e[(i+2)%3][(k+2)%3]
                  - e[(i+1)%3][(k+2)%3] * e[(i+2)%3][(k+1)%3];
    det = e[0][0] * cof[0][0] + e[0][1] * cof[0][1] + e[0][2] * cof[0][2];
    sing = (v[0][0] == 0) || (cof[2][2] == 0) || (det == 0);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        w[i*3+k] = sing ? word_t'(0) : div_round_sat(cof[i][k] <<< 32, det);
    r.inv_00 = w[0]; r.inv_01 = w[1]; r.inv_02 = w[2];
    r.inv_10 = w[3]; r.inv_11 = w[4]; r.inv_12 = w[5];
    r.inv_20 = w[6]; r.inv_21 = w[7]; r.inv_22 = w[8];
    r.order_code = code;
    r.singular   = sing;
    return r;
  endfunction

  // Accepted items and register writes, seen with the values from before the edge.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) inverse_q.push_back(predict_inverse(in_data_i, limit_model));
    if (cfg_valid_i && cfg_ready_o) limit_model <= cfg_data_i;
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    bmi_out_t ex;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data_o);
        errors++;
      end else begin
        ex = inverse_q.pop_front();
        results_seen++;
        if (ex.singular) singular_seen++;
        if (ex.order_code != ORD_NONE) swaps_seen++;
        check_field("inv_00", ex.inv_00, out_data_o.inv_00);
        check_field("inv_01", ex.inv_01, out_data_o.inv_01);
        check_field("inv_02", ex.inv_02, out_data_o.inv_02);
        check_field("inv_10", ex.inv_10, out_data_o.inv_10);
        check_field("inv_11", ex.inv_11, out_data_o.inv_11);
        check_field("inv_12", ex.inv_12, out_data_o.inv_12);
        check_field("inv_20", ex.inv_20, out_data_o.inv_20);
        check_field("inv_21", ex.inv_21, out_data_o.inv_21);
        check_field("inv_22", ex.inv_22, out_data_o.inv_22);
        check_field("order_code", 32'(ex.order_code), 32'(out_data_o.order_code));
        check_field("singular", 32'(ex.singular), 32'(out_data_o.singular));
      end
    end
  end

  // Output stall: one of four patterns, from never stalled to stalled most of the time.
  always @(posedge clk_i) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2: out_stall_i <= ((cycles % 7) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The caller drops valid after the last item; a burst ends in a gap or runs on.
  task automatic send_item(bmi_in_t x);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 1)) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIM_BITS-1:0] lim);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    limit_now = lim;
  endtask

  function automatic word_t near(int unsigned m);
    return word_t'($signed($urandom_range(0, 2 * m)) - $signed(m));
  endfunction

  function automatic bmi_in_t mk(word_t ax, word_t ay, word_t az, word_t bx, word_t by,
                                 word_t bz, word_t cx, word_t cy, word_t cz);
    bmi_in_t x;
    x.a_x = ax; x.a_y = ay; x.a_z = az;
    x.b_x = bx; x.b_y = by; x.b_z = bz;
    x.c_x = cx; x.c_y = cy; x.c_z = cz;
    return x;
  endfunction

  localparam word_t ONE  = 32'sh0001_0000;
  localparam word_t WMAX = 32'sh7fff_ffff;
  localparam word_t WMIN = 32'sh8000_0000;

  task automatic test_directed();
    send_item(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_item(mk(2*ONE, ONE, 0, 0, 3*ONE, ONE, ONE, 0, -ONE));
    send_item(mk(WMAX, 0, 0, 0, WMAX, 0, 0, 0, WMAX));
    send_item(mk(WMIN, 0, 0, 0, WMIN, 0, 0, 0, WMIN));
    send_item(mk(WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 1, -1, WMAX));
    send_item(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));              // saturating inverse
    send_item(mk(-1, 0, 0, 0, -1, 0, 0, 0, -1));
    send_item(mk(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));        // a.x zero: swap a with b
    send_item(mk(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));        // a.x, b.x zero: swap a-c, then b-c
    send_item(mk(ONE, ONE, 0, 2*ONE, 2*ONE, ONE, 0, ONE, 0)); // b parallel to a: swap b, c
    send_item(mk(0, ONE, 0, ONE, 0, 0, 2*ONE, 0, ONE));    // a.x zero: swap a with b only
    send_item(mk(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
    send_item(mk(0, ONE, ONE, 0, 2*ONE, 2*ONE, ONE, ONE, 0)); // a-c only
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));              // all zero: singular
    send_item(mk(ONE, 0, 0, 2*ONE, 0, 0, 0, ONE, 0));      // dependent: singular
    send_item(mk(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 0, 0, ONE));
    send_item(mk(ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0));      // zero determinant
    send_item(mk(3, 5, 7, 11, 13, 17, 19, 23, 29));
  endtask

  task automatic test_wide(int n);
    for (int i = 0; i < n; i++)
      send_item(mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom));
  endtask

  // Moderate vectors with some components pushed near the zero limit.
  task automatic test_near_zero(int n);
    bmi_in_t x;
    int unsigned m;
    for (int i = 0; i < n; i++) begin
      m = 32'(limit_now) + 2;
      x = mk(near(1 << 22), near(1 << 22), near(1 << 22), near(1 << 22), near(1 << 22),
             near(1 << 22), near(1 << 22), near(1 << 22), near(1 << 22));
      if ($urandom_range(0, 1)) x.a_x = near(m);
      if ($urandom_range(0, 2) == 0) x.b_x = near(m);
      if ($urandom_range(0, 3) == 0) x.c_x = near(m);
      send_item(x);
    end
  endtask

  // b close to a multiple of a in the xy plane.
  task automatic test_parallel(int n);
    bmi_in_t x;
    int      k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 6) - 3;
      x = mk(near(1 << 20), near(1 << 20), near(1 << 20), 0, 0, near(1 << 22),
             near(1 << 22), near(1 << 22), near(1 << 22));
      if ($urandom_range(0, 3) == 0) begin
        x.c_x = x.a_x; x.a_x = near(32'(limit_now) + 1);
      end
      x.b_x = x.a_x * k;
      x.b_y = x.a_y * k + near(32'(limit_now) + 1);
      send_item(x);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    limit_model = LIM_RESET;
    limit_now   = LIM_RESET;
    errors = 0; results_seen = 0; singular_seen = 0; swaps_seen = 0;
    cycles = 0; burst_left = 0; stall_mode = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_wide(150);
    test_near_zero(100);
    test_parallel(100);
    write_limit(16'd0);
    test_directed();
    test_near_zero(100);
    test_parallel(80);
    write_limit(16'hffff);
    test_directed();
    test_wide(100);
    test_near_zero(150);
    test_parallel(150);
    write_limit(16'(1 << $urandom_range(0, 15)));
    test_near_zero(150);
    test_parallel(150);
    write_limit(16'($urandom));
    test_wide(100);
    test_near_zero(120);
    test_parallel(120);
    write_limit(16'd1);
    test_near_zero(50);
    test_parallel(50);

    in_valid_i <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Checked %0d inverses (%0d singular, %0d with swaps) over six limit settings.",
             results_seen, singular_seen, swaps_seen);
    if (errors == 0 && inverse_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* basis_matrix_inverse_3x3.f */
sv/bmi_pkg.sv
sv/bmi_cofactor.sv
sv/bmi_div_cell.sv
sv/basis_matrix_inverse_3x3.sv
dv/tb_basis_matrix_inverse_3x3.sv
